### rtl/lfm_pkg.sv
// Shared constants, codes and types of the light flicker modulator.
package lfm_pkg;

   // Parameter defaults
   localparam int LFM_MAX_BURSTS = 8;
   localparam int LFM_SINE_DEPTH = 256;

   // Configuration register indexes
   localparam logic [3:0] CFG_BASE_INTENSITY  = 4'd0;
   localparam logic [3:0] CFG_INTENSITY_DEPTH = 4'd1;
   localparam logic [3:0] CFG_INTENSITY_RATE  = 4'd2;
   localparam logic [3:0] CFG_BASE_RADIUS     = 4'd3;
   localparam logic [3:0] CFG_RADIUS_DEPTH    = 4'd4;
   localparam logic [3:0] CFG_RADIUS_RATE     = 4'd5;
   localparam logic [3:0] CFG_EMISSIVE_LEVEL  = 4'd6;
   localparam logic [3:0] CFG_BURST_COUNT     = 4'd7;

   // Item kinds on the request channel
   localparam logic REQ_TICK  = 1'b0;
   localparam logic REQ_WRITE = 1'b1;

   typedef struct packed {
      logic [15:0] wait_ms;
      logic [15:0] off_ms;
      logic [15:0] jitter_ms;
   } burst_entry_type;

   typedef struct packed {
      logic        neg;
      logic [14:0] mag;
   } sine_out_type;

endpackage

### rtl/lfm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module lfm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/lfm_sine.sv
// Quarter-wave sine lookup: phase to quadrant and table position, registered magnitude and sign.
module lfm_sine #(
   parameter int SINE_TABLE_DEPTH = lfm_pkg::LFM_SINE_DEPTH
) (
   input  logic                 clock,
   input  logic [15:0]          phase_hi,
   output lfm_pkg::sine_out_type sine_out
);
   import lfm_pkg::*;

   localparam int QW = $clog2(4 * SINE_TABLE_DEPTH);
   localparam int KW = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int SW = 16 + QW;
   localparam logic [SW-1:0] SCALE = SW'(4 * SINE_TABLE_DEPTH);
   localparam logic [QW-1:0] Q1_START = QW'(SINE_TABLE_DEPTH);
   localparam logic [QW-1:0] Q2_START = QW'(2 * SINE_TABLE_DEPTH);
   localparam logic [QW-1:0] Q3_START = QW'(3 * SINE_TABLE_DEPTH);
   localparam logic [KW-1:0] K_TOP    = KW'(SINE_TABLE_DEPTH);

   // Q16 polynomial, halved to Q0.15 and clipped
   function automatic logic [14:0] wave_point(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] p;
      x2 = (x * x) >> 16;
      p  = (64'd4640 * x2) >> 16;
      p  = 64'd42047 - p;
      p  = (p * x2) >> 16;
      p  = 64'd102943 - p;
      p  = (p * x) >> 16;
      p  = p >> 1;
      if (p > 64'd32767) begin
         p = 64'd32767;
      end
      return p[14:0];
   endfunction

   logic [14:0] wave [0:SINE_TABLE_DEPTH];

   for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_wave
      localparam logic [63:0] XPOS = (64'(k) << 16) / SINE_TABLE_DEPTH;
      assign wave[k] = wave_point(XPOS);
   end

   logic [SW-1:0] scaled;
   logic [QW-1:0] idx;
   logic [QW-1:0] rem;
   logic [1:0]    quad;
   logic [KW-1:0] pos;
   logic [KW-1:0] addr;
   sine_out_type  sine_out_ff;

   assign scaled = {{QW{1'b0}}, phase_hi} * SCALE;
   assign idx    = scaled[SW-1:16];

   always_comb begin
      if (idx >= Q3_START) begin
         quad = 2'd3;
         rem  = idx - Q3_START;
      end else if (idx >= Q2_START) begin
         quad = 2'd2;
         rem  = idx - Q2_START;
      end else if (idx >= Q1_START) begin
         quad = 2'd1;
         rem  = idx - Q1_START;
      end else begin
         quad = 2'd0;
         rem  = idx;
      end
      pos  = KW'(rem);
      // falling quarters read the table backwards
      addr = quad[0] ? (K_TOP - pos) : pos;
   end

   always_ff @(posedge clock) begin
      sine_out_ff.mag <= wave[addr];
      sine_out_ff.neg <= quad[1];
   end

   assign sine_out = sine_out_ff;

endmodule

### rtl/light_flicker_modulator.sv
// Light flicker modulator top level: tick sequencer, burst table and output register.
// A tick item steps through the phase, sine, multiply and final states; the final state holds
// until the output register is free. The sequencer takes no new item meanwhile, as it shares one
// sine table port and one 17x16 multiplier across three products; table writes give no result.
// Synchronous reset clears configuration, phases, timers and flags; burst table entries remain.
module light_flicker_modulator #(
   parameter int MAX_BURSTS       = lfm_pkg::LFM_MAX_BURSTS,
   parameter int SINE_TABLE_DEPTH = lfm_pkg::LFM_SINE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_type,
   input  logic [9:0]         req_dt_ms,
   input  logic [15:0]        req_random_fraction,
   input  logic [2:0]         req_entry_index,
   input  logic [15:0]        req_entry_wait_ms,
   input  logic [15:0]        req_entry_off_ms,
   input  logic [15:0]        req_entry_jitter_ms,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_light_enabled,
   output logic signed [17:0] rsp_intensity_out,
   output logic signed [17:0] rsp_radius_out,
   output logic [15:0]        rsp_emissive_out,
   input  logic               csr_we,
   input  logic [3:0]         csr_index,
   input  logic [15:0]        csr_wdata
);
   import lfm_pkg::*;

   localparam int IW = (MAX_BURSTS > 1) ? $clog2(MAX_BURSTS) : 1;
   localparam int CW = $clog2(MAX_BURSTS + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_PHASE,
      S_SINE_I,
      S_SINE_R,
      S_MUL_R,
      S_FIN
   } state_type;

   function automatic logic signed [17:0] sat18(input logic signed [18:0] v);
      if (v > 19'sd131071) begin
         return 18'sd131071;
      end else if (v < -19'sd131072) begin
         return -18'sd131072;
      end
      return v[17:0];
   endfunction

   // configuration
   logic [15:0] cfg_base_int_ff, cfg_int_depth_ff, cfg_int_rate_ff;
   logic [15:0] cfg_base_rad_ff, cfg_rad_depth_ff, cfg_rad_rate_ff;
   logic [15:0] cfg_emissive_ff;
   logic [3:0]  cfg_burst_count_ff;

   // persistent state
   state_type          state_ff;
   logic [31:0]        iphase_ff, rphase_ff, ft_ff;
   logic [IW-1:0]      burst_index_ff;
   logic signed [17:0] roff_ff;
   logic               lights_off_ff;
   logic [15:0]        emissive_now_ff;
   logic               rsp_valid_ff;

   // per-tick working registers
   logic [9:0]         dt_ff;
   logic [15:0]        frac_ff;
   logic [IW-1:0]      cur_idx_ff, next_idx_ff;
   logic               count_nz_ff, off_ff, relight_ff;
   logic [15:0]        f_wait_ff, f_jit_ff;
   logic [16:0]        span_ff;
   logic [32:0]        mul_ff;
   logic               neg_i_ff, neg_r_ff;
   logic signed [17:0] inten_ff;
   logic               out_light_ff;
   logic signed [17:0] out_inten_ff, out_rad_ff;
   logic [15:0]        out_emissive_ff;

   // combinational
   logic [CW-1:0]      count_eff;
   logic [IW-1:0]      cur_idx_in, next_idx_in;
   logic [IW:0]        idx_sum;
   logic [25:0]        iinc, rinc;
   logic [31:0]        iphase_in, rphase_in, ft_in;
   logic [32:0]        ft_sum;
   logic signed [19:0] thr;
   logic               off_in, relight_in;
   logic               accept, tick_accept, entry_we, fin_go;
   logic [IW-1:0]      ram_raddr;
   burst_entry_type    ram_wdata, ram_rdata;
   logic [15:0]        sine_phase;
   sine_out_type       sine_q;
   logic [16:0]        mul_a;
   logic [15:0]        mul_b;
   logic signed [18:0] swing_i, swing_r;
   logic signed [18:0] roff_sum;
   logic               lights_off_in;
   logic [15:0]        emissive_in;

   assign accept      = req_valid && req_ready;
   assign tick_accept = accept && (req_type == REQ_TICK);
   assign entry_we    = accept && (req_type == REQ_WRITE) &&
                        (32'(req_entry_index) < MAX_BURSTS);
   assign fin_go      = (state_ff == S_FIN) && (!rsp_valid_ff || rsp_ready);

   assign count_eff = (32'(cfg_burst_count_ff) > MAX_BURSTS) ? CW'(MAX_BURSTS)
                                                             : CW'(cfg_burst_count_ff);
   assign cur_idx_in  = (32'(burst_index_ff) >= 32'(count_eff)) ? '0 : burst_index_ff;
   assign idx_sum     = {1'b0, cur_idx_ff} + 1'b1;
   assign next_idx_in = (32'(idx_sum) >= 32'(count_eff)) ? '0 : idx_sum[IW-1:0];

   // current entry is fetched at acceptance, the following one during the phase step
   assign ram_raddr = (state_ff == S_IDLE) ? cur_idx_in : next_idx_in;
   assign ram_wdata = '{wait_ms: req_entry_wait_ms, off_ms: req_entry_off_ms,
                        jitter_ms: req_entry_jitter_ms};

   lfm_ram #(
      .WIDTH($bits(burst_entry_type)),
      .DEPTH(MAX_BURSTS)
   ) u_burst_ram (
      .clock  (clock),
      .wr_en  (entry_we),
      .wr_addr(IW'(req_entry_index)),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   assign sine_phase = (state_ff == S_SINE_I) ? iphase_ff[31:16] : rphase_ff[31:16];

   lfm_sine #(
      .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
   ) u_sine (
      .clock   (clock),
      .phase_hi(sine_phase),
      .sine_out(sine_q)
   );

   // phase and flicker timing
   assign iinc      = dt_ff * cfg_int_rate_ff;
   assign rinc      = dt_ff * cfg_rad_rate_ff;
   assign iphase_in = iphase_ff + {6'b0, iinc};
   assign rphase_in = rphase_ff + {6'b0, rinc};
   assign ft_sum    = {1'b0, ft_ff} + {23'b0, dt_ff};
   assign ft_in     = ft_sum[32] ? '1 : ft_sum[31:0];

   assign thr = $signed({4'b0, ram_rdata.wait_ms}) + $signed({4'b0, ram_rdata.off_ms}) +
                $signed({{2{roff_ff[17]}}, roff_ff});
   assign off_in     = (count_eff != '0) && (ft_in > {16'b0, ram_rdata.wait_ms});
   assign relight_in = off_in &&
                       ($signed({2'b00, ft_in}) > $signed({{14{thr[19]}}, thr}));

   // one shared multiplier: jitter span, then intensity swing, then radius swing
   always_comb begin
      case (state_ff)
         S_SINE_I: begin
            mul_a = {ram_rdata.jitter_ms, 1'b0};
            mul_b = frac_ff;
         end
         S_SINE_R: begin
            mul_a = {1'b0, cfg_int_depth_ff};
            mul_b = {1'b0, sine_q.mag};
         end
         S_MUL_R: begin
            mul_a = {1'b0, cfg_rad_depth_ff};
            mul_b = {1'b0, sine_q.mag};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign swing_i = neg_i_ff ? -$signed({3'b0, mul_ff[30:15]}) : $signed({3'b0, mul_ff[30:15]});
   assign swing_r = neg_r_ff ? -$signed({3'b0, mul_ff[30:15]}) : $signed({3'b0, mul_ff[30:15]});

   assign roff_sum = $signed({3'b0, f_wait_ff}) - $signed({3'b0, f_jit_ff}) +
                     $signed({2'b0, span_ff});

   assign lights_off_in = relight_ff ? 1'b0 : (off_ff ? 1'b1 : lights_off_ff);
   assign emissive_in   = relight_ff ? cfg_emissive_ff : (off_ff ? 16'd0 : emissive_now_ff);

   // sequencer, configuration and persistent state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= S_IDLE;
         rsp_valid_ff       <= 1'b0;
         cfg_base_int_ff    <= '0;
         cfg_int_depth_ff   <= '0;
         cfg_int_rate_ff    <= '0;
         cfg_base_rad_ff    <= '0;
         cfg_rad_depth_ff   <= '0;
         cfg_rad_rate_ff    <= '0;
         cfg_emissive_ff    <= '0;
         cfg_burst_count_ff <= '0;
         iphase_ff          <= '0;
         rphase_ff          <= '0;
         ft_ff              <= '0;
         burst_index_ff     <= '0;
         roff_ff            <= '0;
         lights_off_ff      <= 1'b0;
         emissive_now_ff    <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CFG_BASE_INTENSITY:  cfg_base_int_ff    <= csr_wdata;
               CFG_INTENSITY_DEPTH: cfg_int_depth_ff   <= csr_wdata;
               CFG_INTENSITY_RATE:  cfg_int_rate_ff    <= csr_wdata;
               CFG_BASE_RADIUS:     cfg_base_rad_ff    <= csr_wdata;
               CFG_RADIUS_DEPTH:    cfg_rad_depth_ff   <= csr_wdata;
               CFG_RADIUS_RATE:     cfg_rad_rate_ff    <= csr_wdata;
               CFG_EMISSIVE_LEVEL:  cfg_emissive_ff    <= csr_wdata;
               CFG_BURST_COUNT:     cfg_burst_count_ff <= csr_wdata[3:0];
               default: ;
            endcase
         end

         if (fin_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (tick_accept) begin
                  state_ff <= S_PHASE;
               end
            end
            S_PHASE: begin
               iphase_ff <= iphase_in;
               rphase_ff <= rphase_in;
               ft_ff     <= ft_in;
               state_ff  <= S_SINE_I;
            end
            S_SINE_I: state_ff <= S_SINE_R;
            S_SINE_R: state_ff <= S_MUL_R;
            S_MUL_R:  state_ff <= S_FIN;
            S_FIN: begin
               // hold until the output register is free
               if (fin_go) begin
                  lights_off_ff   <= lights_off_in;
                  emissive_now_ff <= emissive_in;
                  if (count_nz_ff) begin
                     burst_index_ff <= relight_ff ? next_idx_ff : cur_idx_ff;
                  end
                  if (relight_ff) begin
                     iphase_ff <= '0;
                     rphase_ff <= '0;
                     ft_ff     <= '0;
                     roff_ff   <= (f_jit_ff != '0) ? roff_sum[17:0] : '0;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // datapath working registers
   always_ff @(posedge clock) begin
      // keep the radius product while the result waits
      if (state_ff != S_FIN) begin
         mul_ff <= mul_a * mul_b;
      end
      case (state_ff)
         S_IDLE: begin
            dt_ff      <= req_dt_ms;
            frac_ff    <= req_random_fraction;
            cur_idx_ff <= cur_idx_in;
         end
         S_PHASE: begin
            count_nz_ff <= (count_eff != '0);
            off_ff      <= off_in;
            relight_ff  <= relight_in;
            next_idx_ff <= next_idx_in;
         end
         S_SINE_I: begin
            f_wait_ff <= ram_rdata.wait_ms;
            f_jit_ff  <= ram_rdata.jitter_ms;
         end
         S_SINE_R: begin
            span_ff  <= mul_ff[32:16];
            neg_i_ff <= sine_q.neg;
         end
         S_MUL_R: begin
            neg_r_ff <= sine_q.neg;
            inten_ff <= sat18($signed({3'b0, cfg_base_int_ff}) + swing_i);
         end
         S_FIN: begin
            if (fin_go) begin
               out_light_ff    <= !lights_off_in;
               out_inten_ff    <= relight_ff ? sat18($signed({3'b0, cfg_base_int_ff}))
                                             : inten_ff;
               out_rad_ff      <= sat18($signed({3'b0, cfg_base_rad_ff}) + swing_r);
               out_emissive_ff <= emissive_in;
            end
         end
         default: ;
      endcase
   end

   assign req_ready         = (state_ff == S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_light_enabled = out_light_ff;
   assign rsp_intensity_out = out_inten_ff;
   assign rsp_radius_out    = out_rad_ff;
   assign rsp_emissive_out  = out_emissive_ff;

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_FIN))
      else $error("result raised outside the final step");

   a_dark_emissive: assert property (@(posedge clock) disable iff (reset)
      lights_off_ff |-> (emissive_now_ff == '0))
      else $error("emissive level non-zero while light is off");

   a_relight_clears: assert property (@(posedge clock) disable iff (reset)
      (fin_go && relight_ff) |=> (ft_ff == '0 && iphase_ff == '0 && !lights_off_ff))
      else $error("relight did not clear time, phase and off flag");

   a_index_bound: assert property (@(posedge clock) disable iff (reset)
      32'(burst_index_ff) < MAX_BURSTS)
      else $error("burst index beyond table");

endmodule
